/* rtl/spq_pkg.sv */
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package spq_pkg;

  // Request codes carried by the action field.
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_FULL       = 2'd1;
  localparam logic [1:0] STATUS_EMPTY      = 2'd2;

  // Operation broadcast from the control to every cell of the chain.
  typedef struct packed {
    logic enq;  // insert the new value
    logic deq;  // shift the chain toward cell 0
  } spq_op_t;

endpackage

/* rtl/sorted_priority_queue.sv */
// Sorted priority queue: a chain of QUEUE_DEPTH cells kept largest first.
// A result is registered and appears the cycle after its beat is accepted.
// Throughput: one request per cycle while results are taken; every cell
// updates in parallel with its neighbors for both insert and remove.
// Reset clears the fill count and the output valid; cell contents are
// undefined until written and are never read before that.
`timescale 1ns / 1ps

module sorted_priority_queue import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int VALUE_WIDTH = 16,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic signed [VALUE_WIDTH-1:0] in_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] out_value_o,
  output logic [1:0]                    status_o,
  output logic [CNT_W-1:0]              occupancy_o,
  output logic                          is_empty_o,
  output logic                          is_full_o
);

  logic [CNT_W-1:0]              count_q, count_d;
  logic                          out_valid_q;
  logic signed [VALUE_WIDTH-1:0] out_value_q, out_value_d;
  logic [1:0]                    status_q, status_d;
  logic [CNT_W-1:0]              occupancy_q;
  logic                          is_empty_q, is_full_q;
  logic                          accept, full, empty;
  spq_op_t                       op;

  logic signed [VALUE_WIDTH-1:0] cell_value [QUEUE_DEPTH];
  logic                          cell_disp  [QUEUE_DEPTH];

  // A new beat is taken whenever the result register is free or draining.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty      = (count_q == '0);

  // Decode the request and apply the full and empty guards.
  always_comb begin
    op          = '0;
    status_d    = STATUS_OK;
    out_value_d = '0;
    count_d     = count_q;
    if (accept) begin
      if (action_i == ACT_ENQ) begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          op.enq  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end else begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          op.deq      = 1'b1;
          out_value_d = cell_value[0];
          count_d     = count_q - 1'b1;
        end
      end
    end
  end

  // Chain of cells; cell 0 always holds the largest value.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] left_value, right_value;
    logic                          left_disp;

    if (i == 0) begin : g_first
      assign left_value = '0;
      assign left_disp  = 1'b0;
    end else begin : g_mid
      assign left_value = cell_value[i-1];
      assign left_disp  = cell_disp[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    spq_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CNT_W       (CNT_W),
      .IDX         (i)
    ) u_cell (
      .clk_i         (clk_i),
      .op_i          (op),
      .count_i       (count_q),
      .new_value_i   (in_value_i),
      .left_value_i  (left_value),
      .left_disp_i   (left_disp),
      .right_value_i (right_value),
      .value_o       (cell_value[i]),
      .disp_o        (cell_disp[i])
    );
  end

  // Fill count and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload is captured with each accepted beat.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q <= out_value_d;
      status_q    <= status_d;
      occupancy_q <= count_d;
      is_empty_q  <= (count_d == '0);
      is_full_q   <= (count_d == CNT_W'(QUEUE_DEPTH));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign status_o    = status_q;
  assign occupancy_o = occupancy_q;
  assign is_empty_o  = is_empty_q;
  assign is_full_o   = is_full_q;

endmodule

/* rtl/spq_cell.sv */
// One storage cell of the sorted chain.
// Depends on spq_pkg for the operation struct.
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; #(
  parameter int VALUE_WIDTH = 16,
  parameter int CNT_W       = 5,
  parameter int IDX         = 0
) (
  input  logic                          clk_i,
  input  spq_op_t                       op_i,
  input  logic [CNT_W-1:0]              count_i,
  input  logic signed [VALUE_WIDTH-1:0] new_value_i,
  input  logic signed [VALUE_WIDTH-1:0] left_value_i,
  input  logic                          left_disp_i,
  input  logic signed [VALUE_WIDTH-1:0] right_value_i,
  output logic signed [VALUE_WIDTH-1:0] value_o,
  output logic                          disp_o
);

  logic signed [VALUE_WIDTH-1:0] value_q, value_d;
  logic                          occupied;

  // The cell holds a live entry when it lies below the fill count.
  assign occupied = (count_i > CNT_W'(IDX));

  // The new value belongs at or ahead of this cell when the cell is empty or
  // holds a strictly smaller value; equal values stay ahead of the newcomer.
  assign disp_o  = !occupied || (value_q < new_value_i);
  assign value_o = value_q;

  // Insert: the first displaced cell takes the new value, later ones take
  // their left neighbor. Remove: every cell takes its right neighbor.
  always_comb begin
    value_d = value_q;
    if (op_i.enq) begin
      if (disp_o && !left_disp_i) begin
        value_d = new_value_i;
      end else if (disp_o) begin
        value_d = left_value_i;
      end
    end else if (op_i.deq) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule
